@@ design/assert_macros.svh @@
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the synchronous reset is held.
`define WBPS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define WBPS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/wbps_pkg.sv @@
`timescale 1ns / 1ps

package wbps_pkg;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_BEGIN  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_REGION = 2'd2;

  // A pattern byte with this value matches any region byte.
  localparam logic [7:0] WILDCARD_BYTE = 8'h2A;

  // Width of the reported match offset.
  localparam int unsigned MATCH_OFFSET_W = 32;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic clear;   // begin a new job
    logic append;  // shift a new pattern byte into the chain
    logic scan;    // advance the partial-match bits by one region byte
  } cell_ctrl_t;

  // One result beat.
  typedef struct packed {
    logic                      found;
    logic [MATCH_OFFSET_W-1:0] match_offset;
  } result_t;

endpackage

@@ design/wbps_ifs.sv @@
`timescale 1ns / 1ps

// Request channel: one beat is a begin, a pattern byte or a region byte.
interface wbps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic       region_end;

  modport source (output valid, output req_type, output data_byte, output region_end,
                  input ready);
  modport sink (input valid, input req_type, input data_byte, input region_end,
                output ready);
endinterface

// Result channel: one beat per finished job.
interface wbps_out_if;
  logic                                valid;
  logic                                ready;
  logic                                found;
  logic [wbps_pkg::MATCH_OFFSET_W-1:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink (input valid, input found, input match_offset, output ready);
endinterface

@@ design/wildcard_byte_pattern_scan_core.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// A job's result goes to the output register, or to the skid entry while the output is held.
// Throughput: one request beat per cycle; every pattern position is compared at once.
// Requests stall only while the output register and its skid entry both hold results.
// Reset (rst_n low, synchronous) clears length, match bits, position, done and output valid.
// Pattern bytes are not reset; only loaded positions are ever compared.

module wildcard_byte_pattern_scan_core #(
  parameter int unsigned MAX_PATTERN = 512,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  wbps_in_if.sink    in_chan,
  wbps_out_if.source out_chan
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);

  // The pattern lives in a chain of cells. Appending shifts every cell up
  // by one and loads the new byte into cell 0, so cell 0 always holds the
  // last pattern byte and its partial-match bit is the full-match flag.
  // Each cell takes its shorter-prefix bit from the cell above it, and the
  // first empty cell above the pattern feeds a constant one.

  logic                 accept;
  logic                 can_append;
  logic                 space_ok;
  wbps_pkg::cell_ctrl_t ctrl;

  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic                   done_r, done_nxt;

  logic [7:0] pat_w    [MAX_PATTERN];
  logic       loaded_w [MAX_PATTERN];
  logic       pm_w     [MAX_PATTERN];
  logic       feed_w   [MAX_PATTERN];
  logic       hit_w    [MAX_PATTERN];

  logic                   hit;
  logic                   res_valid;
  logic [OFFSET_BITS-1:0] start_pos;
  wbps_pkg::result_t      res;

  assign in_chan.ready = space_ok;
  assign accept        = in_chan.valid && in_chan.ready;

  // Appends are taken only before the first region byte of a live job and
  // while the pattern has room.
  assign can_append = !done_r && (pos_r == '0) && (len_r < LEN_W'(MAX_PATTERN));

  always_comb begin
    ctrl.clear  = accept && (in_chan.req_type == wbps_pkg::REQ_BEGIN);
    ctrl.append = accept && (in_chan.req_type == wbps_pkg::REQ_APPEND) && can_append;
    ctrl.scan   = accept && (in_chan.req_type == wbps_pkg::REQ_REGION) && !done_r;
  end

  genvar k;
  generate
    for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
      logic [7:0] pat_in_w;
      logic       loaded_in_w;
      logic       pm_in_w;
      logic       feed_in_w;

      if (k == 0) begin : g_bottom
        assign pat_in_w    = in_chan.data_byte;
        assign loaded_in_w = 1'b1;
        assign pm_in_w     = 1'b0;
      end else begin : g_shift
        assign pat_in_w    = pat_w[k-1];
        assign loaded_in_w = loaded_w[k-1];
        assign pm_in_w     = pm_w[k-1];
      end

      if (k == MAX_PATTERN - 1) begin : g_top
        assign feed_in_w = 1'b1;
      end else begin : g_feed
        assign feed_in_w = feed_w[k+1];
      end

      wbps_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .scan_byte  (in_chan.data_byte),
        .pat_in     (pat_in_w),
        .loaded_in  (loaded_in_w),
        .pm_in      (pm_in_w),
        .feed_in    (feed_in_w),
        .pat_out    (pat_w[k]),
        .loaded_out (loaded_w[k]),
        .pm_out     (pm_w[k]),
        .feed_out   (feed_w[k]),
        .hit_out    (hit_w[k])
      );
    end
  endgenerate

  // An empty pattern leaves cell 0 unloaded, so it can never hit.
  assign hit       = ctrl.scan && hit_w[0];
  assign res_valid = ctrl.scan && (hit || in_chan.region_end);
  assign start_pos = pos_r - OFFSET_BITS'(len_r - LEN_W'(1));

  always_comb begin
    res.found        = hit;
    res.match_offset = hit ? wbps_pkg::MATCH_OFFSET_W'(start_pos) : '0;
  end

  always_comb begin
    len_nxt  = len_r;
    pos_nxt  = pos_r;
    done_nxt = done_r;
    if (ctrl.clear) begin
      len_nxt  = '0;
      pos_nxt  = '0;
      done_nxt = 1'b0;
    end else if (ctrl.append) begin
      len_nxt = len_r + LEN_W'(1);
    end else if (ctrl.scan) begin
      pos_nxt = pos_r + OFFSET_BITS'(1);
      if (res_valid) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      pos_r  <= '0;
      done_r <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      pos_r  <= pos_nxt;
      done_r <= done_nxt;
    end
  end

  wbps_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .space_ok  (space_ok),
    .out_chan  (out_chan)
  );

  `WBPS_ASSERT(a_result_closes_job, clk, rst_n, res_valid |=> done_r, "job still open after its result")
  `WBPS_ASSERT(a_hit_needs_pattern, clk, rst_n, hit |-> (len_r != '0), "match reported with empty pattern")
  `WBPS_ASSERT(a_len_bound, clk, rst_n, len_r <= LEN_W'(MAX_PATTERN), "pattern length past capacity")
  `WBPS_ASSERT(a_done_blocks_scan, clk, rst_n, done_r |-> !ctrl.scan, "scan advanced after job done")

endmodule

@@ design/wbps_cell.sv @@
`timescale 1ns / 1ps

// One pattern position: its pattern byte, a loaded flag and one
// partial-match bit. Cell k holds pattern byte (length - 1 - k).
module wbps_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wbps_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]           scan_byte,
  input  logic [7:0]           pat_in,
  input  logic                 loaded_in,
  input  logic                 pm_in,
  input  logic                 feed_in,
  output logic [7:0]           pat_out,
  output logic                 loaded_out,
  output logic                 pm_out,
  output logic                 feed_out,
  output logic                 hit_out
);

  logic [7:0] pat_r;
  logic       loaded_r;
  logic       pm_r;
  logic       byte_match;

  assign byte_match = (pat_r == wbps_pkg::WILDCARD_BYTE) || (pat_r == scan_byte);
  // New partial-match value: the shorter prefix matched one byte earlier and this byte matches.
  assign hit_out    = loaded_r & feed_in & byte_match;
  // An empty cell above the pattern acts as an always-matched empty prefix.
  assign feed_out   = loaded_r ? pm_r : 1'b1;

  assign pat_out    = pat_r;
  assign loaded_out = loaded_r;
  assign pm_out     = pm_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      loaded_r <= 1'b0;
      pm_r     <= 1'b0;
    end else if (ctrl.append) begin
      loaded_r <= loaded_in;
      pm_r     <= pm_in;
    end else if (ctrl.scan) begin
      pm_r <= hit_out;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.append) begin
      pat_r <= pat_in;
    end
  end

endmodule

@@ design/wbps_skid.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Output register with one skid entry behind it.
module wbps_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  wbps_pkg::result_t res,
  output logic              space_ok,
  wbps_out_if.source        out_chan
);

  logic              out_valid_r;
  logic              skid_valid_r;
  wbps_pkg::result_t out_r;
  wbps_pkg::result_t skid_r;
  logic              out_free;

  assign out_free = !out_valid_r || out_chan.ready;
  assign space_ok = !skid_valid_r;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.found        = out_r.found;
  assign out_chan.match_offset = out_r.match_offset;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (!out_free && res_valid) begin
      skid_r <= res;
    end
  end

  `WBPS_ASSERT(a_skid_behind_out, clk, rst_n, skid_valid_r |-> out_valid_r, "skid full while output empty")
  `WBPS_ASSERT(a_no_result_when_full, clk, rst_n, skid_valid_r |-> !res_valid, "result arrived with skid full")

endmodule

@@ tb/sv/wbps_scan_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the scan core, keeps its own shift-and predictor and
// compares every accepted result beat with the oldest predicted one.
module wbps_scan_checker #(
  parameter int unsigned MAX_PATTERN = 512,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  wbps_in_if   in_mon,
  wbps_out_if  out_mon,
  output int   fail_count,
  output int   pending
);

  logic [7:0]             pat_mem [MAX_PATTERN];
  int                     pat_len;
  logic [MAX_PATTERN-1:0] live_bits;
  logic [OFFSET_BITS-1:0] scan_pos;
  logic                   scan_done;
  wbps_pkg::result_t      match_q [$];

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic byte_hits(int j, logic [7:0] b);
    return (pat_mem[j] == wbps_pkg::WILDCARD_BYTE) || (pat_mem[j] == b);
  endfunction

  task automatic absorb_request(logic [1:0] req, logic [7:0] b, logic last);
    wbps_pkg::result_t      r;
    logic                   hit;
    logic [OFFSET_BITS-1:0] start;
    case (req)
      wbps_pkg::REQ_BEGIN: begin
        pat_len   = 0;
        live_bits = '0;
        scan_pos  = '0;
        scan_done = 1'b0;
      end
      wbps_pkg::REQ_APPEND: begin
        if (!scan_done && scan_pos == '0 && pat_len < MAX_PATTERN) begin
          pat_mem[pat_len] = b;
          pat_len++;
        end
      end
      wbps_pkg::REQ_REGION: begin
        if (!scan_done) begin
          hit = 1'b0;
          if (pat_len > 0) begin
            for (int j = pat_len - 1; j > 0; j--)
              live_bits[j] = live_bits[j-1] && byte_hits(j, b);
            live_bits[0] = byte_hits(0, b);
            hit = live_bits[pat_len-1];
          end
          if (hit) begin
            start          = scan_pos - OFFSET_BITS'(pat_len - 1);
            r.found        = 1'b1;
            r.match_offset = wbps_pkg::MATCH_OFFSET_W'(start);
            match_q.push_back(r);
            scan_done = 1'b1;
          end else if (last) begin
            r.found        = 1'b0;
            r.match_offset = '0;
            match_q.push_back(r);
            scan_done = 1'b1;
          end
          scan_pos = scan_pos + OFFSET_BITS'(1);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    wbps_pkg::result_t want;
    if (!rst_n) begin
      pat_len   = 0;
      live_bits = '0;
      scan_pos  = '0;
      scan_done = 1'b0;
      match_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        absorb_request(in_mon.req_type, in_mon.data_byte, in_mon.region_end);
      if (out_mon.valid && out_mon.ready) begin
        if (match_q.size() == 0) begin
          report($sformatf("unexpected result beat found=%0b offset=%0d",
                           out_mon.found, out_mon.match_offset));
        end else begin
          want = match_q.pop_front();
          if (out_mon.found !== want.found)
            report($sformatf("found is %0b, predicted %0b", out_mon.found, want.found));
          if (out_mon.match_offset !== want.match_offset)
            report($sformatf("match_offset is %0d, predicted %0d",
                             out_mon.match_offset, want.match_offset));
        end
      end
    end
    pending = match_q.size();
  end

endmodule

@@ tb/sv/wildcard_byte_pattern_scan_core_tb.sv @@
`timescale 1ns / 1ps

// Top of the scan core bench. It makes request beats, throttles the result
// channel and gives the verdict; prediction and comparison live in the checker.
module wildcard_byte_pattern_scan_core_tb;

  localparam int unsigned MAX_PAT   = 512;
  localparam int unsigned OFF_BITS  = 32;
  localparam int          BEAT_GOAL = 1850;

  // The block gives request type 3 no meaning; it should be dropped silently.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   beats_sent;
  // While set, neither side inserts idle cycles, so back-to-back beats occur.
  bit   steady;

  wbps_in_if  in_if ();
  wbps_out_if out_if ();

  wildcard_byte_pattern_scan_core #(
    .MAX_PATTERN(MAX_PAT),
    .OFFSET_BITS(OFF_BITS)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if.sink),
    .out_chan(out_if.source)
  );

  wbps_scan_checker #(
    .MAX_PATTERN(MAX_PAT),
    .OFFSET_BITS(OFF_BITS)
  ) scan_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Result side: before each beat it draws a random stall during which ready
  // is held low, then keeps ready high until a beat is taken.
  initial begin
    int stall;
    out_if.ready = 1'b0;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 10);
      repeat (stall) begin
        @(negedge clk);
        out_if.ready <= 1'b0;
      end
      @(negedge clk);
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && rst_n));
    end
  end

  // Sends one request beat. Inputs change only at the falling edge; ready is
  // sampled at the rising edge, where it is the value the block acts on.
  // During the idle gap the payload carries junk to show it is ignored.
  task automatic send_beat(logic [1:0] req, logic [7:0] b, logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk);
      in_if.valid      <= 1'b0;
      in_if.req_type   <= 2'($urandom);
      in_if.data_byte  <= 8'($urandom);
      in_if.region_end <= 1'($urandom);
    end
    @(negedge clk);
    in_if.valid      <= 1'b1;
    in_if.req_type   <= req;
    in_if.data_byte  <= b;
    in_if.region_end <= last;
    do @(posedge clk); while (!in_if.ready);
    if (req != REQ_UNUSED)
      beats_sent++;
  endtask

  // Bytes for patterns and regions. The narrow alphabet makes false starts and
  // overlapping partial matches common; it includes the wildcard value so that
  // a literal 0x2A shows up in regions as well.
  function automatic logic [7:0] pick_byte(bit narrow);
    logic [7:0] pick;
    if (!narrow) begin
      pick = 8'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0: pick = 8'h00;
        1: pick = 8'hFF;
        2: pick = wbps_pkg::WILDCARD_BYTE;
        default: pick = 8'h55;
      endcase
    end
    return pick;
  endfunction

  // One job: begin, the pattern bytes, then the region. When plant is set a
  // copy of the pattern (wildcards filled with whatever is there) is written
  // into the region, so a match is likely. Untidy jobs sprinkle in unused
  // requests, appends during the scan, early region ends and a missing region
  // end; any job may be followed by stray region bytes after it is over.
  task automatic run_job(int plen, int rlen, bit tidy, bit plant);
    logic [7:0] pat [$];
    logic [7:0] region [$];
    bit         narrow;
    bit         drop_end;
    int         at;
    int         fit;
    logic       last;
    narrow   = $urandom_range(0, 1);
    drop_end = !tidy && ($urandom_range(0, 5) == 0);
    for (int i = 0; i < plen; i++)
      pat.push_back(($urandom_range(0, 3) == 0) ? wbps_pkg::WILDCARD_BYTE
                                                 : pick_byte(narrow));
    for (int i = 0; i < rlen; i++)
      region.push_back(pick_byte(narrow));
    // Only the first MAX_PAT bytes of an overlong pattern are ever stored.
    fit = (plen > MAX_PAT) ? MAX_PAT : plen;
    if (plant && fit > 0 && fit <= rlen) begin
      at = $urandom_range(0, rlen - fit);
      for (int i = 0; i < fit; i++)
        if (pat[i] != wbps_pkg::WILDCARD_BYTE)
          region[at+i] = pat[i];
    end

    send_beat(wbps_pkg::REQ_BEGIN, 8'($urandom), 1'($urandom));
    foreach (pat[i]) begin
      if (!tidy && $urandom_range(0, 15) == 0)
        send_beat(REQ_UNUSED, 8'($urandom), 1'($urandom));
      send_beat(wbps_pkg::REQ_APPEND, pat[i], 1'($urandom));
    end
    foreach (region[i]) begin
      if (!tidy) begin
        case ($urandom_range(0, 19))
          0: send_beat(wbps_pkg::REQ_APPEND, 8'($urandom), 1'($urandom));
          1: send_beat(REQ_UNUSED, 8'($urandom), 1'($urandom));
          default: ;
        endcase
      end
      last = (i == rlen - 1) ? !drop_end : (!tidy && $urandom_range(0, 29) == 0);
      send_beat(wbps_pkg::REQ_REGION, region[i], last);
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3))
        send_beat(wbps_pkg::REQ_REGION, pick_byte(narrow), 1'($urandom));
  endtask

  initial begin
    int  plen;
    int  rlen;
    int  pick;
    bit  big_done;
    rst_n            = 1'b0;
    steady           = 1'b0;
    beats_sent       = 0;
    big_done         = 1'b0;
    in_if.valid      = 1'b0;
    in_if.req_type   = wbps_pkg::REQ_BEGIN;
    in_if.data_byte  = 8'h00;
    in_if.region_end = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part.
    // Right after reset the pattern is empty, so the region end reports not found.
    send_beat(wbps_pkg::REQ_REGION, 8'h00, 1'b1);
    // Wildcard followed by 0xFF; the match completes on the byte that ends
    // the region and must be reported as found at offset 0.
    send_beat(wbps_pkg::REQ_BEGIN, 8'hFF, 1'b1);
    send_beat(wbps_pkg::REQ_APPEND, wbps_pkg::WILDCARD_BYTE, 1'b1);
    send_beat(wbps_pkg::REQ_APPEND, 8'hFF, 1'b0);
    send_beat(wbps_pkg::REQ_REGION, 8'h00, 1'b0);
    send_beat(wbps_pkg::REQ_REGION, 8'hFF, 1'b1);
    // The job is over: region bytes and appends are dropped without a result.
    send_beat(wbps_pkg::REQ_REGION, 8'hFF, 1'b1);
    send_beat(wbps_pkg::REQ_APPEND, 8'h11, 1'b1);
    // A literal pattern byte does not match a region byte of 0x2A.
    send_beat(wbps_pkg::REQ_BEGIN, 8'h00, 1'b0);
    send_beat(wbps_pkg::REQ_APPEND, 8'h00, 1'b0);
    send_beat(wbps_pkg::REQ_REGION, wbps_pkg::WILDCARD_BYTE, 1'b0);
    send_beat(wbps_pkg::REQ_REGION, 8'hFF, 1'b1);
    // Region shorter than the pattern: nothing can complete.
    send_beat(wbps_pkg::REQ_BEGIN, 8'h00, 1'b0);
    send_beat(wbps_pkg::REQ_APPEND, 8'h41, 1'b0);
    send_beat(wbps_pkg::REQ_APPEND, 8'h42, 1'b0);
    send_beat(wbps_pkg::REQ_APPEND, 8'h43, 1'b0);
    send_beat(wbps_pkg::REQ_REGION, 8'h41, 1'b0);
    send_beat(wbps_pkg::REQ_REGION, 8'h42, 1'b1);
    // An append after the scan has started is dropped, so 0x55 still matches
    // alone at offset 1.
    send_beat(wbps_pkg::REQ_BEGIN, 8'h00, 1'b0);
    send_beat(wbps_pkg::REQ_APPEND, 8'h55, 1'b0);
    send_beat(wbps_pkg::REQ_REGION, 8'h10, 1'b0);
    send_beat(wbps_pkg::REQ_APPEND, 8'h10, 1'b0);
    send_beat(wbps_pkg::REQ_REGION, 8'h55, 1'b0);
    // Unused request type with every payload bit set.
    send_beat(REQ_UNUSED, 8'hFF, 1'b1);

    // Random part: mostly short well-formed jobs with random content, once a
    // job that fills the pattern store past its end and scans a full-length
    // match through the top partial-match bit.
    while (beats_sent < BEAT_GOAL) begin
      steady = ($urandom_range(0, 4) == 0);
      if (!big_done && beats_sent > 400) begin
        big_done = 1'b1;
        run_job(MAX_PAT + 2, MAX_PAT + $urandom_range(0, 6), 1'b1, 1'b1);
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0)
          plen = 0;
        else if (pick < 3)
          plen = $urandom_range(7, 16);
        else
          plen = $urandom_range(1, 6);
        rlen = $urandom_range(0, 24);
        run_job(plen, rlen, $urandom_range(0, 3) != 0, $urandom_range(0, 2) != 0);
      end
    end
    steady = 1'b0;

    @(negedge clk);
    in_if.valid <= 1'b0;
    // Drain: every predicted result must arrive, then a short settle in which
    // a stray extra result beat would still be caught.
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
